// ----- hdl/temperature_threshold_arbiter_unit_macros.svh -----
// Assertion macros shared by the checker files of the threshold arbiter.
// Depends on nothing; every macro samples on clock and is disabled by reset.
`ifndef TEMPERATURE_THRESHOLD_ARBITER_UNIT_MACROS_SVH
`define TEMPERATURE_THRESHOLD_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TTA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TTA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tta_pkg.sv -----
// Package of the temperature threshold arbiter: shared constants and types.
// Used by the table, the top level and the checker; depends on nothing.
package tta_pkg;

   // Default sizing of the block.
   localparam int NUM_REQUESTERS_DEFAULT = 16;
   localparam int TEMP_BITS_DEFAULT      = 16;

   // Fixed widths of the item fields.
   localparam int FIELD_BITS = 16;
   localparam int REQ_BITS   = 4;

   // Command codes.
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Access controls from the sequencer to the request table.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tbl_ctrl_type;

endpackage

// ----- hdl/tta_table.sv -----
// Request table of the threshold arbiter: one synchronous memory plus presence bits.
// Depends on tta_pkg for the access control struct.
module tta_table #(
   parameter int NUM_REQUESTERS = tta_pkg::NUM_REQUESTERS_DEFAULT,
   parameter int TEMP_BITS      = tta_pkg::TEMP_BITS_DEFAULT,
   localparam int IW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1,
   localparam int EW = 2 * TEMP_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tta_pkg::tbl_ctrl_type ctrl,
   input  logic [IW-1:0]         wr_addr,
   input  logic [EW-1:0]         wr_data,
   output logic                  wr_present,
   input  logic [IW-1:0]         rd_addr,
   output logic [EW-1:0]         rd_data
);

   logic [EW-1:0]             entry_mem [NUM_REQUESTERS];
   logic [NUM_REQUESTERS-1:0] present_ff;
   logic [NUM_REQUESTERS-1:0] present_in;
   logic [EW-1:0]             rd_data_ff;
   logic                      rd_present_ff;

   // Presence of the entry being written, used to decide whether a clear acts.
   assign wr_present = present_ff[wr_addr];

   // Any write marks its entry present; reset makes every entry absent.
   always_comb begin
      present_in = present_ff;
      if (ctrl.wr_en) begin
         present_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff    <= entry_mem[rd_addr];
         rd_present_ff <= present_ff[rd_addr];
      end
   end

   // An absent entry reads as having no valid trips.
   assign rd_data = rd_present_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/temperature_threshold_arbiter_unit.sv -----
// Top level of the temperature threshold arbiter: sequencer, check and scan logic.
// Depends on tta_pkg and instantiates tta_table.
//
// Usage: the req_ channel carries one command per item: a store of a
// requester's low/high trip request checked against the current temperature,
// or a clear of a requester's entry. The rsp_ channel returns exactly one
// item per request: rejected, changed, and the arbitrated low (highest valid
// low trip) and high (lowest valid high trip) with their valid flags.
// Both channels use valid/ready; an item moves when both are high.
// A rejected store or a clear of an absent entry goes from the check step
// straight to the output register; a request that updates the table passes
// through the check step, a scan that reads every table entry once through
// the single memory read port, a drain step and a resolve step before its
// result enters the output register.
// One request is processed at a time; req_ready rises again once the result
// has moved into the output register, so a new item is taken only after the
// previous one is through.
// Reset empties the table and makes both arbitrated trips invalid.
// When the receiver stalls, the result holds in the output register and a
// following result waits until that register is free.
module temperature_threshold_arbiter_unit #(
   parameter int NUM_REQUESTERS = tta_pkg::NUM_REQUESTERS_DEFAULT,
   parameter int TEMP_BITS      = tta_pkg::TEMP_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [tta_pkg::REQ_BITS-1:0]   req_requester,
   input  logic [tta_pkg::FIELD_BITS-1:0] req_low_trip,
   input  logic                           req_low_trip_valid,
   input  logic [tta_pkg::FIELD_BITS-1:0] req_high_trip,
   input  logic                           req_high_trip_valid,
   input  logic [tta_pkg::FIELD_BITS-1:0] req_current_temp,
   input  logic                           req_current_valid,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_rejected,
   output logic                           rsp_changed,
   output logic [tta_pkg::FIELD_BITS-1:0] rsp_arb_low,
   output logic                           rsp_arb_low_valid,
   output logic [tta_pkg::FIELD_BITS-1:0] rsp_arb_high,
   output logic                           rsp_arb_high_valid
);

   localparam int IW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
   localparam int EW = 2 * TEMP_BITS + 2;
   localparam int TB = TEMP_BITS;
   localparam int FW = tta_pkg::FIELD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE,
      ST_EMIT
   } state_type;

   // Sequencer state and captured request.
   state_type                    state_ff, state_in;
   logic                         cmd_ff, cmd_in;
   logic [tta_pkg::REQ_BITS-1:0] requester_ff, requester_in;
   logic [TB-1:0]                lo_ff, lo_in, hi_ff, hi_in, cur_ff, cur_in;
   logic                         lo_ok_ff, lo_ok_in, hi_ok_ff, hi_ok_in;
   logic                         cur_ok_ff, cur_ok_in;
   // Scan counter, read-valid flag and running extremes.
   logic [IW-1:0]                scan_ff, scan_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [TB-1:0]                acc_lo_ff, acc_lo_in, acc_hi_ff, acc_hi_in;
   logic                         acc_lo_ok_ff, acc_lo_ok_in, acc_hi_ok_ff, acc_hi_ok_in;
   // Arbitrated trips held between requests.
   logic [TB-1:0]                arb_lo_ff, arb_lo_in, arb_hi_ff, arb_hi_in;
   logic                         arb_lo_ok_ff, arb_lo_ok_in, arb_hi_ok_ff, arb_hi_ok_in;
   // Pending result flags and the output register.
   logic                         res_rej_ff, res_rej_in, res_chg_ff, res_chg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_rej_ff, rsp_rej_in, rsp_chg_ff, rsp_chg_in;
   logic [FW-1:0]                rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic                         rsp_lo_ok_ff, rsp_lo_ok_in, rsp_hi_ok_ff, rsp_hi_ok_in;

   // Table interface.
   tta_pkg::tbl_ctrl_type tbl_ctrl;
   logic [IW-1:0]         tbl_wr_addr;
   logic [EW-1:0]         tbl_wr_data;
   logic                  tbl_wr_present;
   logic [EW-1:0]         tbl_rd_data;

   // Decoded request and table read data.
   logic          in_range, bad_store, out_free;
   logic          rd_lo_ok, rd_hi_ok, take_lo, take_hi, trips_differ;
   logic [TB-1:0] rd_lo, rd_hi;

   tta_table #(
      .NUM_REQUESTERS (NUM_REQUESTERS),
      .TEMP_BITS      (TEMP_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tbl_ctrl),
      .wr_addr    (tbl_wr_addr),
      .wr_data    (tbl_wr_data),
      .wr_present (tbl_wr_present),
      .rd_addr    (scan_ff),
      .rd_data    (tbl_rd_data)
   );

   // Request checks against the current temperature and the table size.
   assign in_range  = int'(requester_ff) < NUM_REQUESTERS;
   assign bad_store = !in_range
                   || (lo_ok_ff && (!cur_ok_ff || lo_ff > cur_ff))
                   || (hi_ok_ff && (!cur_ok_ff || hi_ff < cur_ff));

   // Table write: a store writes the request, a clear writes empty trips.
   assign tbl_wr_addr = IW'(requester_ff);
   always_comb begin
      if (cmd_ff == tta_pkg::CMD_STORE) begin
         tbl_wr_data = {lo_ok_ff, lo_ok_ff ? lo_ff : '0, hi_ok_ff, hi_ok_ff ? hi_ff : '0};
      end else begin
         tbl_wr_data = '0;
      end
   end

   // Fields of the entry read during the scan.
   assign rd_lo_ok = tbl_rd_data[EW-1];
   assign rd_lo    = tbl_rd_data[EW-2 -: TB];
   assign rd_hi_ok = tbl_rd_data[TB];
   assign rd_hi    = tbl_rd_data[TB-1:0];
   assign take_lo  = rd_lo_ok && (!acc_lo_ok_ff || rd_lo > acc_lo_ff);
   assign take_hi  = rd_hi_ok && (!acc_hi_ok_ff || rd_hi < acc_hi_ff);

   // New extremes differ from the held ones in a valid bit or a valid value.
   assign trips_differ = (acc_lo_ok_ff != arb_lo_ok_ff)
                      || (acc_lo_ok_ff && acc_lo_ff != arb_lo_ff)
                      || (acc_hi_ok_ff != arb_hi_ok_ff)
                      || (acc_hi_ok_ff && acc_hi_ff != arb_hi_ff);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next-state logic of the sequencer. The table write completes in the check
   // step before the scan reads it, so reads never overlap a pending write.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      requester_in = requester_ff;
      lo_in        = lo_ff;
      lo_ok_in     = lo_ok_ff;
      hi_in        = hi_ff;
      hi_ok_in     = hi_ok_ff;
      cur_in       = cur_ff;
      cur_ok_in    = cur_ok_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      acc_lo_in    = acc_lo_ff;
      acc_lo_ok_in = acc_lo_ok_ff;
      acc_hi_in    = acc_hi_ff;
      acc_hi_ok_in = acc_hi_ok_ff;
      arb_lo_in    = arb_lo_ff;
      arb_lo_ok_in = arb_lo_ok_ff;
      arb_hi_in    = arb_hi_ff;
      arb_hi_ok_in = arb_hi_ok_ff;
      res_rej_in   = res_rej_ff;
      res_chg_in   = res_chg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rej_in   = rsp_rej_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_lo_ok_in = rsp_lo_ok_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_hi_ok_in = rsp_hi_ok_ff;
      tbl_ctrl     = '0;
      req_ready    = 1'b0;

      // Fold the entry read in the previous cycle into the running extremes.
      if (rd_vld_ff) begin
         if (take_lo) begin
            acc_lo_ok_in = 1'b1;
            acc_lo_in    = rd_lo;
         end
         if (take_hi) begin
            acc_hi_ok_in = 1'b1;
            acc_hi_in    = rd_hi;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in       = req_command;
               requester_in = req_requester;
               lo_in        = TB'(req_low_trip);
               lo_ok_in     = req_low_trip_valid;
               hi_in        = TB'(req_high_trip);
               hi_ok_in     = req_high_trip_valid;
               cur_in       = TB'(req_current_temp);
               cur_ok_in    = req_current_valid;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_rej_in   = 1'b0;
            res_chg_in   = 1'b0;
            scan_in      = '0;
            acc_lo_in    = '0;
            acc_lo_ok_in = 1'b0;
            acc_hi_in    = '0;
            acc_hi_ok_in = 1'b0;
            if (cmd_ff == tta_pkg::CMD_STORE) begin
               if (bad_store) begin
                  res_rej_in = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  tbl_ctrl.wr_en = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else if (in_range && tbl_wr_present) begin
               tbl_ctrl.wr_en = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            tbl_ctrl.rd_en = 1'b1;
            rd_vld_in      = 1'b1;
            if (scan_ff == IW'(NUM_REQUESTERS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            res_chg_in = trips_differ;
            if (trips_differ) begin
               arb_lo_in    = acc_lo_ff;
               arb_lo_ok_in = acc_lo_ok_ff;
               arb_hi_in    = acc_hi_ff;
               arb_hi_ok_in = acc_hi_ok_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = res_rej_ff;
               rsp_chg_in   = res_chg_ff;
               rsp_lo_ok_in = arb_lo_ok_ff;
               rsp_lo_in    = arb_lo_ok_ff ? FW'(arb_lo_ff) : '0;
               rsp_hi_ok_in = arb_hi_ok_ff;
               rsp_hi_in    = arb_hi_ok_ff ? FW'(arb_hi_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         arb_lo_ff    <= '0;
         arb_lo_ok_ff <= 1'b0;
         arb_hi_ff    <= '0;
         arb_hi_ok_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         arb_lo_ff    <= arb_lo_in;
         arb_lo_ok_ff <= arb_lo_ok_in;
         arb_hi_ff    <= arb_hi_in;
         arb_hi_ok_ff <= arb_hi_ok_in;
      end
      cmd_ff       <= cmd_in;
      requester_ff <= requester_in;
      lo_ff        <= lo_in;
      lo_ok_ff     <= lo_ok_in;
      hi_ff        <= hi_in;
      hi_ok_ff     <= hi_ok_in;
      cur_ff       <= cur_in;
      cur_ok_ff    <= cur_ok_in;
      scan_ff      <= scan_in;
      acc_lo_ff    <= acc_lo_in;
      acc_lo_ok_ff <= acc_lo_ok_in;
      acc_hi_ff    <= acc_hi_in;
      acc_hi_ok_ff <= acc_hi_ok_in;
      res_rej_ff   <= res_rej_in;
      res_chg_ff   <= res_chg_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_lo_ok_ff <= rsp_lo_ok_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_hi_ok_ff <= rsp_hi_ok_in;
   end

   // Result port.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rejected       = rsp_rej_ff;
   assign rsp_changed        = rsp_chg_ff;
   assign rsp_arb_low        = rsp_lo_ff;
   assign rsp_arb_low_valid  = rsp_lo_ok_ff;
   assign rsp_arb_high       = rsp_hi_ff;
   assign rsp_arb_high_valid = rsp_hi_ok_ff;

endmodule

// ----- hdl/tta_checker.sv -----
// Port-level checker of the threshold arbiter, bound to the top level below.
// Depends on tta_pkg and temperature_threshold_arbiter_unit_macros.svh.
`include "temperature_threshold_arbiter_unit_macros.svh"

module tta_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_command,
   input logic [tta_pkg::REQ_BITS-1:0]   req_requester,
   input logic [tta_pkg::FIELD_BITS-1:0] req_low_trip,
   input logic                           req_low_trip_valid,
   input logic [tta_pkg::FIELD_BITS-1:0] req_high_trip,
   input logic                           req_high_trip_valid,
   input logic [tta_pkg::FIELD_BITS-1:0] req_current_temp,
   input logic                           req_current_valid,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_rejected,
   input logic                           rsp_changed,
   input logic [tta_pkg::FIELD_BITS-1:0] rsp_arb_low,
   input logic                           rsp_arb_low_valid,
   input logic [tta_pkg::FIELD_BITS-1:0] rsp_arb_high,
   input logic                           rsp_arb_high_valid
);

   logic [2*tta_pkg::FIELD_BITS+3:0] rsp_payload;

   // The whole result payload, which a stalled item must keep.
   assign rsp_payload = {rsp_rejected, rsp_changed, rsp_arb_low, rsp_arb_low_valid,
                         rsp_arb_high, rsp_arb_high_valid};

   `TTA_ASSERT_NEXT(a_rsp_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")
   `TTA_ASSERT_SAME(a_reject_no_change, rsp_valid && rsp_rejected, !rsp_changed, "rejected item flagged as changed")
   `TTA_ASSERT_SAME(a_invalid_trips_zero, rsp_valid, (rsp_arb_low_valid || rsp_arb_low == '0) && (rsp_arb_high_valid || rsp_arb_high == '0), "invalid arbitrated trip not zero")
   `TTA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second item taken while one is in work")

endmodule

bind temperature_threshold_arbiter_unit tta_checker u_tta_checker (.*);
